// ===== hw/rtl/osd_pkg.sv =====
// ----------------------------------------------------------------------------
// osd_pkg
// Shared types for the obfuscated string decoder: the input and result item
// layouts and the batch of result items that one character can produce.
// ----------------------------------------------------------------------------
package osd_pkg;

	// Largest number of result items that one character can cause.
	localparam int MAX_BATCH = 6;
	localparam int BATCH_CNT_W = $clog2(MAX_BATCH + 1);

	// Header padding codes.
	localparam logic [1:0] PAD_DROP_TWO = 2'd1;
	localparam logic [1:0] PAD_DROP_ONE = 2'd2;

	// One character of encoded text.
	typedef struct packed {
		logic [7:0] in_char;
		logic       is_last;
	} in_item_t;

	// One decoded result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_message;
	} out_item_t;

	// Result items produced by one character, in delivery order.
	typedef struct packed {
		logic [BATCH_CNT_W-1:0]           count;
		out_item_t [MAX_BATCH-1:0]        items;
	} batch_t;

endpackage

// ===== hw/rtl/obfuscated_string_decoder_unit.sv =====
// Path: an accepted character is held in the input register until its whole
// batch is written into the queue, whose head drives the result port.
// Throughput: one character per cycle; result items leave one per cycle while
// result_stall is low, from a QUEUE_DEPTH-entry queue; input stalls while the
// queue cannot take the whole batch (up to six items) of the registered character.
// Reset: arst_n clears the message state, the input valid flag and the queue.
// ----------------------------------------------------------------------------
// obfuscated_string_decoder_unit
// Streaming decoder for a base64-like text with a header byte, tail padding
// and a bit exchange on every emitted byte.
// ----------------------------------------------------------------------------
module obfuscated_string_decoder_unit import osd_pkg::*; #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_stall,
	input  in_item_t  char_item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result_item
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	in_item_t         item_s1;
	logic             valid_s1;
	batch_t           batch;
	logic [CNT_W-1:0] fill;
	logic [CNT_W:0]   need;
	logic             advance;
	logic             accept;

	// The registered character moves on once its whole batch fits the queue.
	assign need       = {1'b0, fill} + (CNT_W+1)'(batch.count);
	assign advance    = valid_s1 && (need <= (CNT_W+1)'(QUEUE_DEPTH));
	assign char_stall = valid_s1 && !advance;
	assign accept     = char_valid && !char_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= char_item;
		end
	end

	osd_decode_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.fire   (advance),
		.batch  (batch)
	);

	osd_item_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (advance),
		.batch  (batch),
		.fill   (fill),
		.valid  (result_valid),
		.stall  (result_stall),
		.head   (result_item)
	);

endmodule

// ===== hw/rtl/osd_decode_core.sv =====
// ----------------------------------------------------------------------------
// osd_decode_core
// Message state and the per-character decode: sextet lookup, group assembly,
// header capture, held group and padding removal at the end of a message.
// ----------------------------------------------------------------------------
module osd_decode_core import osd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t item,
	input  logic     fire,
	output batch_t   batch
);

	// Alphabet anchors.
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_UNDER   = 8'h5f;
	localparam logic [7:0] CH_DOT     = 8'h2e;

	// Map one character to its six-bit value; foreign characters give zero.
	function automatic logic [5:0] sextet_of(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c inside {[8'h41:8'h5a]}) begin
			v = c - CH_UPPER_A;
		end else if (c inside {[8'h61:8'h7a]}) begin
			v = c - CH_LOWER_A + 8'd26;
		end else if (c inside {[8'h30:8'h39]}) begin
			v = c - CH_DIGIT_0 + 8'd52;
		end else if (c == CH_UNDER) begin
			v = 8'd62;
		end else if (c == CH_DOT) begin
			v = 8'd63;
		end
		return v[5:0];
	endfunction

	// Keep bits 7 and 3, exchange the pairs 6/0, 5/1 and 4/2.
	function automatic logic [7:0] permute_bits(input logic [7:0] b);
		return {b[7], b[0], b[1], b[2], b[3], b[4], b[5], b[6]};
	endfunction

	// Byte k of a held group, first byte in the top bits.
	function automatic logic [7:0] held_byte(input logic [23:0] h, input logic [1:0] k);
		logic [7:0] r;
		case (k)
			2'd0:    r = h[23:16];
			2'd1:    r = h[15:8];
			default: r = h[7:0];
		endcase
		return r;
	endfunction

	logic [1:0]  pos_q;
	logic [17:0] accum_q;
	logic [23:0] held_q;
	logic [1:0]  held_cnt_q;
	logic        seen_q;
	logic [1:0]  pad_q;

	logic [1:0]  pos_n;
	logic [17:0] accum_n;
	logic [23:0] held_n;
	logic [1:0]  held_cnt_n;
	logic        seen_n;
	logic [1:0]  pad_n;

	logic [5:0]  sext;
	logic [23:0] grp;
	logic [1:0]  n_old;
	logic [1:0]  drop;
	logic [1:0]  keep;
	logic [1:0]  n_new;
	logic [2:0]  total;

	// Next state of the message after this character.
	always_comb begin
		sext       = sextet_of(item.in_char);
		grp        = {accum_q, sext};
		pos_n      = pos_q;
		accum_n    = accum_q;
		held_n     = held_q;
		held_cnt_n = held_cnt_q;
		seen_n     = seen_q;
		pad_n      = pad_q;
		n_old      = 2'd0;
		if (pos_q == 2'd3) begin
			// A group completes: the previous held group is released.
			n_old = held_cnt_q;
			if (!seen_q) begin
				pad_n      = grp[17:16];
				seen_n     = 1'b1;
				held_n     = {grp[15:0], 8'h00};
				held_cnt_n = 2'd2;
			end else begin
				held_n     = grp;
				held_cnt_n = 2'd3;
			end
			pos_n   = 2'd0;
			accum_n = 18'd0;
		end else begin
			accum_n = {accum_q[11:0], sext};
			pos_n   = pos_q + 2'd1;
		end
	end

	// Padding removal on the held group at the end of a message.
	always_comb begin
		case (pad_n)
			PAD_DROP_TWO: drop = 2'd2;
			PAD_DROP_ONE: drop = 2'd1;
			default:      drop = 2'd0;
		endcase
		keep  = (held_cnt_n > drop) ? (held_cnt_n - drop) : 2'd0;
		n_new = item.is_last ? keep : 2'd0;
		total = {1'b0, n_old} + {1'b0, n_new};
	end

	// Assemble the result items: released bytes, then the kept tail.
	always_comb begin
		logic [2:0] idx;
		logic [7:0] raw;
		batch.items = '0;
		for (int i = 0; i < MAX_BATCH; i++) begin
			idx = 3'(i);
			raw = 8'h00;
			if (idx < total) begin
				if (idx < {1'b0, n_old}) begin
					raw = held_byte(held_q, idx[1:0]);
				end else begin
					raw = held_byte(held_n, 2'(idx - {1'b0, n_old}));
				end
				batch.items[i].out_byte       = permute_bits(raw);
				batch.items[i].byte_valid     = 1'b1;
				batch.items[i].end_of_message = item.is_last && (idx == total - 3'd1);
			end
		end
		if (item.is_last && (total == 3'd0)) begin
			// A message with no data bytes still closes with one marker item.
			batch.items[0].out_byte       = 8'h00;
			batch.items[0].byte_valid     = 1'b0;
			batch.items[0].end_of_message = 1'b1;
			batch.count                   = BATCH_CNT_W'(1);
		end else begin
			batch.count = BATCH_CNT_W'(total);
		end
	end

	// Message state; the end of a message returns everything to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= 2'd0;
			accum_q    <= 18'd0;
			held_q     <= 24'd0;
			held_cnt_q <= 2'd0;
			seen_q     <= 1'b0;
			pad_q      <= 2'd0;
		end else if (fire) begin
			if (item.is_last) begin
				pos_q      <= 2'd0;
				accum_q    <= 18'd0;
				held_q     <= 24'd0;
				held_cnt_q <= 2'd0;
				seen_q     <= 1'b0;
				pad_q      <= 2'd0;
			end else begin
				pos_q      <= pos_n;
				accum_q    <= accum_n;
				held_q     <= held_n;
				held_cnt_q <= held_cnt_n;
				seen_q     <= seen_n;
				pad_q      <= pad_n;
			end
		end
	end

endmodule

// ===== hw/rtl/osd_item_queue.sv =====
// ----------------------------------------------------------------------------
// osd_item_queue
// Result queue that takes a whole batch of items at once and delivers them
// one per cycle, while stall is low, on the result channel.
// ----------------------------------------------------------------------------
module osd_item_queue import osd_pkg::*; #(
	parameter  int DEPTH = 8,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  batch_t           batch,
	output logic [CNT_W-1:0] fill,
	output logic             valid,
	input  logic             stall,
	output out_item_t        head
);

	out_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	logic [PTR_W-1:0] slot [MAX_BATCH];
	logic [PTR_W-1:0] wr_ptr_n;
	logic [PTR_W:0]   wr_sum;
	logic [CNT_W-1:0] push_n;
	logic             pop;

	// Slot of each batch item, wrapped once around the ring.
	always_comb begin
		logic [PTR_W:0] s;
		for (int i = 0; i < MAX_BATCH; i++) begin
			s = {1'b0, wr_ptr_q} + (PTR_W+1)'(i);
			if (s >= (PTR_W+1)'(DEPTH)) begin
				s = s - (PTR_W+1)'(DEPTH);
			end
			slot[i] = s[PTR_W-1:0];
		end
		wr_sum = {1'b0, wr_ptr_q} + (PTR_W+1)'(batch.count);
		if (wr_sum >= (PTR_W+1)'(DEPTH)) begin
			wr_sum = wr_sum - (PTR_W+1)'(DEPTH);
		end
		wr_ptr_n = wr_sum[PTR_W-1:0];
		push_n   = push ? CNT_W'(batch.count) : CNT_W'(0);
	end

	assign valid = (fill_q != CNT_W'(0));
	assign pop   = valid && !stall;
	assign head  = mem_q[rd_ptr_q];
	assign fill  = fill_q;

	// Item storage.
	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < MAX_BATCH; i++) begin
				if (BATCH_CNT_W'(i) < batch.count) begin
					mem_q[slot[i]] <= batch.items[i];
				end
			end
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_n;
			end
			if (pop) begin
				if (rd_ptr_q == PTR_W'(DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + PTR_W'(1);
				end
			end
			fill_q <= fill_q + push_n - (pop ? CNT_W'(1) : CNT_W'(0));
		end
	end

endmodule

// ===== hw/rtl/osd_checker.sv =====
// ----------------------------------------------------------------------------
// osd_checker
// Port-level checks for the obfuscated string decoder, bound to the top level.
// ----------------------------------------------------------------------------
module osd_checker import osd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      char_valid,
	input logic      char_stall,
	input in_item_t  char_item,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result_item
);

	// An item without a data byte only ever closes a message.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_item.byte_valid |-> result_item.end_of_message)
		else $error("empty result item without end of message");

	// The end marker of an empty message carries a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_item.byte_valid |-> (result_item.out_byte == 8'h00))
		else $error("empty result item with a nonzero byte");

	// Input stall only begins right after a character was taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(char_stall) |-> $past(char_valid && !char_stall))
		else $error("input stall raised with no character pending");

	// A stalled result item holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_item))
		else $error("stalled result item changed");

endmodule

bind obfuscated_string_decoder_unit osd_checker u_checker (.*);
